>>> rtl/core/rwt_pkg.sv
`default_nettype none

package rwt_pkg;

  // Event kinds carried on s_tuser
  localparam logic [2:0] ACT_BEGIN     = 3'd0;
  localparam logic [2:0] ACT_APPLY     = 3'd1;
  localparam logic [2:0] ACT_ACCEPTED  = 3'd2;
  localparam logic [2:0] ACT_FAILED    = 3'd3;
  localparam logic [2:0] ACT_CONNECTED = 3'd4;
  localparam logic [2:0] ACT_TIMED_OUT = 3'd5;
  localparam logic [2:0] ACT_CANCEL    = 3'd6;
  localparam logic [2:0] ACT_SNAPSHOT  = 3'd7;

  // Workflow stages
  localparam logic [1:0] ST_IDLE       = 2'd0;
  localparam logic [1:0] ST_AWAIT_CFG  = 2'd1;
  localparam logic [1:0] ST_APPLYING   = 2'd2;
  localparam logic [1:0] ST_AWAIT_CONN = 2'd3;

  // Begin/apply dispositions
  localparam logic [1:0] DISP_STARTED   = 2'd0;
  localparam logic [1:0] DISP_DUPLICATE = 2'd1;
  localparam logic [1:0] DISP_STALE     = 2'd2;
  localparam logic [1:0] DISP_UPDATED   = 2'd3;

  // Finish kinds
  localparam logic [1:0] FIN_NONE      = 2'd0;
  localparam logic [1:0] FIN_COMPLETED = 2'd1;
  localparam logic [1:0] FIN_FAILED    = 2'd2;

  localparam int REV_W  = 64;
  localparam int GTAG_W = 32;
  localparam int STAG_W = 16;
  localparam int CODE_W = 8;

  typedef struct packed {
    logic [2:0]        action;
    logic [REV_W-1:0]  new_revision;
    logic [GTAG_W-1:0] gen_tag;
    logic [STAG_W-1:0] seq_tag;
    logic [CODE_W-1:0] error_code;
  } event_t;

  typedef struct packed {
    logic [1:0]        disposition;
    logic              ok;
    logic [GTAG_W-1:0] gen_out;
    logic [STAG_W-1:0] seq_out;
    logic [REV_W-1:0]  rev_out;
    logic [1:0]        stage_out;
    logic [REV_W-1:0]  last_done_out;
    logic [1:0]        finish_kind;
    logic [CODE_W-1:0] fail_code;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/restart_workflow_tracker.sv
`default_nettype none

// Channel   Dir  Handshake         Payload
// s_*       in   s_tvalid/tready   s_tuser: action; s_tdata: revision, tags, error code
// m_*       out  m_tvalid/tready   m_tdata: one result per event (see port comment)
//
// Each event passes through the input register, then the state update and result
// are computed in a single combinational pass and written to the result
// register. One event per cycle is sustained while m_tready is held high; the
// input register drains whenever the result register is empty or being taken,
// so s_tready follows m_tready only when both registers hold an event.
// rst is synchronous: it clears the workflow, sets the generation counter
// to 1 and empties both registers.

module restart_workflow_tracker #(
  parameter int GEN_BITS = 32,
  parameter int SEQ_BITS = 16
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  // [63:0] new_revision, [95:64] gen_tag, [111:96] seq_tag, [119:112] error_code
  input  wire  [119:0] s_tdata,
  // [2:0] action
  input  wire  [2:0]   s_tuser,
  output logic         m_tvalid,
  input  wire          m_tready,
  // [1:0] disposition, [2] ok, [34:3] gen_out, [50:35] seq_out, [114:51] rev_out,
  // [116:115] stage_out, [180:117] last_done_out, [182:181] finish_kind,
  // [190:183] fail_code, [191] zero
  output logic [191:0] m_tdata
);

  localparam int GCW = (GEN_BITS > rwt_pkg::GTAG_W) ? GEN_BITS : rwt_pkg::GTAG_W;
  localparam int SCW = (SEQ_BITS > rwt_pkg::STAG_W) ? SEQ_BITS : rwt_pkg::STAG_W;

  // Input register
  logic            in_valid;
  rwt_pkg::event_t in_ev;
  logic            advance;

  // Result register
  logic             out_valid;
  rwt_pkg::result_t res;
  rwt_pkg::result_t res_next;

  // Workflow state
  logic                busy, busy_next;
  logic [1:0]          stage, stage_next;
  logic [GEN_BITS-1:0] cur_gen, cur_gen_next;
  logic [63:0]         cur_rev, cur_rev_next;
  logic [SEQ_BITS-1:0] apply_count, apply_count_next;
  logic [GEN_BITS-1:0] gen_counter, gen_counter_next;
  logic [63:0]         last_done_rev, last_done_rev_next;

  logic       gen_match, seq_match, rev_stale, count_full;
  logic [GCW-1:0] gen_rep;
  logic [SCW-1:0] seq_rep;
  logic [63:0]    rev_rep;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  // Pack disposition, the first result field, into the lowest bits
  assign m_tdata  = {1'b0, res.fail_code, res.finish_kind, res.last_done_out,
                     res.stage_out, res.rev_out, res.seq_out, res.gen_out,
                     res.ok, res.disposition};

  // Tags compare against the full stored values
  assign gen_match  = (GCW'(cur_gen) == GCW'(in_ev.gen_tag));
  assign seq_match  = (SCW'(apply_count) == SCW'(in_ev.seq_tag));
  assign rev_stale  = (in_ev.new_revision != 64'd0) &&
                      (in_ev.new_revision <= last_done_rev);
  assign count_full = (apply_count == {SEQ_BITS{1'b1}});

  always_comb begin
    busy_next          = busy;
    stage_next         = stage;
    cur_gen_next       = cur_gen;
    cur_rev_next       = cur_rev;
    apply_count_next   = apply_count;
    gen_counter_next   = gen_counter;
    last_done_rev_next = last_done_rev;
    res_next             = '0;
    res_next.disposition = rwt_pkg::DISP_STARTED;
    res_next.finish_kind = rwt_pkg::FIN_NONE;

    case (in_ev.action)
      rwt_pkg::ACT_BEGIN: begin
        if (busy) begin
          res_next.disposition = rwt_pkg::DISP_DUPLICATE;
        end else begin
          busy_next        = 1'b1;
          stage_next       = rwt_pkg::ST_AWAIT_CFG;
          cur_gen_next     = gen_counter;
          gen_counter_next = gen_counter + GEN_BITS'(1);
          cur_rev_next     = 64'd0;
          apply_count_next = '0;
        end
      end
      rwt_pkg::ACT_APPLY: begin
        if (rev_stale) begin
          res_next.disposition = rwt_pkg::DISP_STALE;
        end else if (!busy) begin
          busy_next        = 1'b1;
          stage_next       = rwt_pkg::ST_APPLYING;
          cur_gen_next     = gen_counter;
          gen_counter_next = gen_counter + GEN_BITS'(1);
          cur_rev_next     = in_ev.new_revision;
          apply_count_next = SEQ_BITS'(1);
        end else if (apply_count != '0 && cur_rev == in_ev.new_revision) begin
          res_next.disposition = rwt_pkg::DISP_DUPLICATE;
        end else if (in_ev.new_revision != 64'd0 && cur_rev != 64'd0 &&
                     in_ev.new_revision < cur_rev) begin
          res_next.disposition = rwt_pkg::DISP_STALE;
        end else begin
          cur_rev_next = in_ev.new_revision;
          // Hold the count at its ceiling
          if (!count_full) begin
            apply_count_next = apply_count + SEQ_BITS'(1);
          end
          stage_next           = rwt_pkg::ST_APPLYING;
          res_next.disposition = rwt_pkg::DISP_UPDATED;
        end
      end
      rwt_pkg::ACT_ACCEPTED, rwt_pkg::ACT_FAILED: begin
        if (busy && gen_match && seq_match && stage == rwt_pkg::ST_APPLYING) begin
          res_next.ok = 1'b1;
          if (in_ev.action == rwt_pkg::ACT_ACCEPTED) begin
            stage_next = rwt_pkg::ST_AWAIT_CONN;
          end else begin
            busy_next            = 1'b0;
            res_next.finish_kind = rwt_pkg::FIN_FAILED;
            res_next.fail_code   = in_ev.error_code;
          end
        end
      end
      rwt_pkg::ACT_CONNECTED: begin
        if (busy && stage != rwt_pkg::ST_AWAIT_CFG) begin
          if (cur_rev != 64'd0 && cur_rev > last_done_rev) begin
            last_done_rev_next = cur_rev;
          end
          busy_next            = 1'b0;
          res_next.ok          = 1'b1;
          res_next.finish_kind = rwt_pkg::FIN_COMPLETED;
        end
      end
      rwt_pkg::ACT_TIMED_OUT: begin
        // Detach only; no finish is reported
        if (busy && gen_match) begin
          busy_next   = 1'b0;
          res_next.ok = 1'b1;
        end
      end
      rwt_pkg::ACT_CANCEL: begin
        if (busy) begin
          busy_next            = 1'b0;
          res_next.ok          = 1'b1;
          res_next.finish_kind = rwt_pkg::FIN_FAILED;
          res_next.fail_code   = in_ev.error_code;
        end
      end
      default: begin
      end
    endcase

    // Closing a workflow clears its fields
    if (!busy_next) begin
      stage_next       = rwt_pkg::ST_IDLE;
      cur_gen_next     = '0;
      cur_rev_next     = 64'd0;
      apply_count_next = '0;
    end

    // Report the live workflow, or the one this event ended, else zeros
    if (busy_next) begin
      gen_rep = GCW'(cur_gen_next);
      seq_rep = SCW'(apply_count_next);
      rev_rep = cur_rev_next;
    end else if (res_next.ok) begin
      gen_rep = GCW'(cur_gen);
      seq_rep = SCW'(apply_count);
      rev_rep = cur_rev;
    end else begin
      gen_rep = '0;
      seq_rep = '0;
      rev_rep = 64'd0;
    end

    res_next.gen_out       = gen_rep[rwt_pkg::GTAG_W-1:0];
    res_next.seq_out       = seq_rep[rwt_pkg::STAG_W-1:0];
    res_next.rev_out       = rev_rep;
    res_next.stage_out     = stage_next;
    res_next.last_done_out = last_done_rev_next;
  end

  // Handshake registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ev.action       <= s_tuser;
      in_ev.new_revision <= s_tdata[63:0];
      in_ev.gen_tag      <= s_tdata[95:64];
      in_ev.seq_tag      <= s_tdata[111:96];
      in_ev.error_code   <= s_tdata[119:112];
    end
    if (advance) begin
      res <= res_next;
    end
  end

  // Workflow state advances once per event
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      stage         <= rwt_pkg::ST_IDLE;
      cur_gen       <= '0;
      cur_rev       <= 64'd0;
      apply_count   <= '0;
      gen_counter   <= GEN_BITS'(1);
      last_done_rev <= 64'd0;
    end else if (advance) begin
      busy          <= busy_next;
      stage         <= stage_next;
      cur_gen       <= cur_gen_next;
      cur_rev       <= cur_rev_next;
      apply_count   <= apply_count_next;
      gen_counter   <= gen_counter_next;
      last_done_rev <= last_done_rev_next;
    end
  end

endmodule

`default_nettype wire
